### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/ffd_pkg.sv
// Shared types, constants and helpers for the fixed frame deframer.
// No dependencies; used by every module of the block.
package ffd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int CNT_W           = 6;
    localparam int LEN_W           = 6;
    localparam int BYTE_W          = 8;
    localparam int HDR_BYTES       = 4;
    localparam int FRAME_EXTRA     = 5;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [BYTE_W-1:0] SYNC0 = 8'hBB;
    localparam logic [BYTE_W-1:0] SYNC1 = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2 = 8'h57;

    localparam logic [CNT_W-1:0] POS_SYNC0 = 6'd0;
    localparam logic [CNT_W-1:0] POS_SYNC1 = 6'd1;
    localparam logic [CNT_W-1:0] POS_SYNC2 = 6'd2;
    localparam logic [CNT_W-1:0] POS_LEN   = 6'd3;

    localparam logic [LEN_W-1:0] EXPECTED_LEN_RST = 6'd1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SYNC = 2'd1,
        ST_LEN  = 2'd2,
        ST_CSUM = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_HOLD
    } back_state_t;

    function automatic int addr_w(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### rtl/ffd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ffd_pkg for the address width helper.
module ffd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [ffd_pkg::addr_w(DEPTH)-1:0]      waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [ffd_pkg::addr_w(DEPTH)-1:0]      raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ffd_front.sv
// Front end: counts frame bytes, checks header and XOR, stores payload, queues a command.
// Depends on ffd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffd_front #(
    parameter int MAX_PAYLOAD = ffd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    input  logic [ffd_pkg::BYTE_W-1:0]              rx_byte,
    output logic                                    full,
    input  logic [ffd_pkg::LEN_W-1:0]               expected_len,
    input  logic                                    q_full,
    input  logic                                    frame_done,
    output logic                                    cmd_push,
    output ffd_pkg::cmd_t                           cmd,
    output logic                                    ram_we,
    output logic [ffd_pkg::addr_w(MAX_PAYLOAD)-1:0] ram_waddr,
    output logic [ffd_pkg::BYTE_W-1:0]              ram_wdata
);

    localparam int AW = ffd_pkg::addr_w(MAX_PAYLOAD);
    localparam logic [ffd_pkg::LEN_W-1:0] LEN_MAX = ffd_pkg::LEN_W'(MAX_PAYLOAD);

    logic [ffd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ffd_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic                       sync_reg, sync_next;
    logic                       lgood_reg, lgood_next;
    logic                       pend_reg, pend_next;

    logic [ffd_pkg::LEN_W-1:0]  len_eff;
    logic [ffd_pkg::CNT_W:0]    pos_x;
    logic [ffd_pkg::CNT_W:0]    len_x;
    logic                       accept;
    logic                       in_payload;
    logic                       frame_end;
    logic                       sync_chk;
    logic                       lgood_chk;
    logic [ffd_pkg::BYTE_W-1:0] xor_chk;
    ffd_pkg::status_t           status_chk;

    always_comb
    begin
        if (expected_len == '0)
        begin
            len_eff = ffd_pkg::LEN_W'(1);
        end
        else if (expected_len > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = expected_len;
        end
    end

    assign full       = q_full | pend_reg;
    assign accept     = push & ~full;
    assign pos_x      = {1'b0, cnt_reg};
    assign len_x      = {1'b0, len_eff};
    assign in_payload = (pos_x >= (ffd_pkg::CNT_W+1)'(ffd_pkg::HDR_BYTES))
                        && (pos_x < len_x + (ffd_pkg::CNT_W+1)'(ffd_pkg::HDR_BYTES));
    assign frame_end  = (pos_x + (ffd_pkg::CNT_W+1)'(1))
                        >= (len_x + (ffd_pkg::CNT_W+1)'(ffd_pkg::FRAME_EXTRA));

    assign sync_chk  = sync_reg
                       & ~((cnt_reg == ffd_pkg::POS_SYNC0) && (rx_byte != ffd_pkg::SYNC0))
                       & ~((cnt_reg == ffd_pkg::POS_SYNC1) && (rx_byte != ffd_pkg::SYNC1))
                       & ~((cnt_reg == ffd_pkg::POS_SYNC2) && (rx_byte != ffd_pkg::SYNC2));
    assign lgood_chk = lgood_reg
                       & ~((cnt_reg == ffd_pkg::POS_LEN) && (rx_byte != {2'b00, len_eff}));
    assign xor_chk   = xor_reg ^ rx_byte;

    always_comb
    begin
        if (!sync_chk)
        begin
            status_chk = ffd_pkg::ST_SYNC;
        end
        else if (!lgood_chk)
        begin
            status_chk = ffd_pkg::ST_LEN;
        end
        else if (xor_chk != '0)
        begin
            status_chk = ffd_pkg::ST_CSUM;
        end
        else
        begin
            status_chk = ffd_pkg::ST_OK;
        end
    end

    assign ram_we     = accept & in_payload;
    assign ram_waddr  = AW'(cnt_reg - ffd_pkg::CNT_W'(ffd_pkg::HDR_BYTES));
    assign ram_wdata  = rx_byte;
    assign cmd_push   = accept & frame_end;
    assign cmd.status = status_chk;
    assign cmd.len    = len_eff;

    always_comb
    begin
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        sync_next  = sync_reg;
        lgood_next = lgood_reg;
        pend_next  = pend_reg;
        if (frame_done)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            if (frame_end)
            begin
                cnt_next   = '0;
                xor_next   = '0;
                sync_next  = 1'b1;
                lgood_next = 1'b1;
                pend_next  = (status_chk == ffd_pkg::ST_OK);
            end
            else
            begin
                cnt_next   = cnt_reg + ffd_pkg::CNT_W'(1);
                xor_next   = xor_chk;
                sync_next  = sync_chk;
                lgood_next = lgood_chk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            xor_reg   <= '0;
            sync_reg  <= 1'b1;
            lgood_reg <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            sync_reg  <= sync_next;
            lgood_reg <= lgood_next;
            pend_reg  <= pend_next;
        end
    end

    `FFD_ASSERT(a_pend_set, clk, rst_n, (cmd_push && cmd.status == ffd_pkg::ST_OK) |=> pend_reg, "good frame did not block the front")
    `FFD_ASSERT_NEVER(a_no_wr_busy, clk, rst_n, ram_we && pend_reg, "payload write while back end reads")

endmodule

### rtl/ffd_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on ffd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffd_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ffd_pkg::cmd_t  wr_cmd,
    output logic           full,
    input  logic           pop,
    output ffd_pkg::cmd_t  rd_cmd,
    output logic           empty
);

    localparam int PW = ffd_pkg::addr_w(ffd_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(ffd_pkg::CMDQ_DEPTH + 1);

    ffd_pkg::cmd_t   entry_reg [ffd_pkg::CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(ffd_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ffd_pkg::CMDQ_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ffd_pkg::CMDQ_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `FFD_ASSERT_NEVER(a_no_ovf, clk, rst_n, push && full, "command pushed into a full queue")

endmodule

### rtl/ffd_back.sv
// Back end: takes commands, reads payload from RAM, drives the result register.
// Depends on ffd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffd_back #(
    parameter int MAX_PAYLOAD = ffd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_valid,
    input  ffd_pkg::cmd_t                           cmd,
    output logic                                    cmd_pop,
    output logic [ffd_pkg::addr_w(MAX_PAYLOAD)-1:0] ram_raddr,
    input  logic [ffd_pkg::BYTE_W-1:0]              ram_rdata,
    output logic                                    frame_done,
    input  logic                                    pop,
    output logic                                    empty,
    output logic [ffd_pkg::BYTE_W-1:0]              payload_byte,
    output logic                                    last,
    output logic [1:0]                              status
);

    localparam int AW = ffd_pkg::addr_w(MAX_PAYLOAD);

    ffd_pkg::back_state_t        state_reg, state_next;
    logic [ffd_pkg::LEN_W-1:0]   idx_reg, idx_next;
    logic [ffd_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [ffd_pkg::BYTE_W-1:0]  pbyte_reg, pbyte_next;
    logic                        last_reg, last_next;
    ffd_pkg::status_t            status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        pbyte_next  = pbyte_reg;
        last_next   = last_reg;
        status_next = status_reg;
        cmd_pop     = 1'b0;
        frame_done  = 1'b0;
        case (state_reg)
            ffd_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.status != ffd_pkg::ST_OK)
                    begin
                        pbyte_next  = '0;
                        last_next   = 1'b1;
                        status_next = cmd.status;
                        state_next  = ffd_pkg::BK_HOLD;
                    end
                    else
                    begin
                        len_next    = cmd.len;
                        idx_next    = '0;
                        status_next = ffd_pkg::ST_OK;
                        state_next  = ffd_pkg::BK_FETCH;
                    end
                end
            end
            ffd_pkg::BK_FETCH:
            begin
                pbyte_next = ram_rdata;
                last_next  = (idx_reg + ffd_pkg::LEN_W'(1) == len_reg);
                state_next = ffd_pkg::BK_HOLD;
            end
            ffd_pkg::BK_HOLD:
            begin
                if (pop)
                begin
                    if (last_reg)
                    begin
                        frame_done = (status_reg == ffd_pkg::ST_OK);
                        state_next = ffd_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ffd_pkg::LEN_W'(1);
                        state_next = ffd_pkg::BK_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ffd_pkg::BK_IDLE;
            end
        endcase
    end

    assign ram_raddr    = idx_next[AW-1:0];
    assign empty        = (state_reg != ffd_pkg::BK_HOLD);
    assign payload_byte = pbyte_reg;
    assign last         = last_reg;
    assign status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffd_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        pbyte_reg  <= pbyte_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    `FFD_ASSERT(a_fetch_hold, clk, rst_n, (state_reg == ffd_pkg::BK_FETCH) |=> (state_reg == ffd_pkg::BK_HOLD), "RAM read not followed by a result")

endmodule

### rtl/fixed_frame_deframer_xor_check.sv
// Top level of the fixed frame deframer with XOR check.
// Depends on ffd_pkg, ffd_ram, ffd_front, ffd_cmd_fifo and ffd_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | push / full        | rx_byte
//  result   | pop / empty        | payload_byte, last, status
//  config   | cfg_we             | cfg_data (expected_len)
//
// One byte is taken per cycle unless a good frame waits or the command queue is full.
// After the checksum byte of a good frame, full stays high until all L payload
// bytes are popped; with the back end idle the first payload result goes from the
// command queue through FETCH to HOLD, and each later one through FETCH again
// after the previous pop. A bad frame's status result skips FETCH (back end idle).
// Reset clears control state only; the payload RAM has no clearing pass.
module fixed_frame_deframer_xor_check #(
    parameter int MAX_PAYLOAD = ffd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [ffd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [ffd_pkg::BYTE_W-1:0]  payload_byte,
    output logic                        last,
    output logic [1:0]                  status,
    input  logic                        cfg_we,
    input  logic [ffd_pkg::LEN_W-1:0]   cfg_data
);

    localparam int AW = ffd_pkg::addr_w(MAX_PAYLOAD);

    logic [ffd_pkg::LEN_W-1:0]  expected_len_reg;
    logic                       q_full;
    logic                       q_empty;
    logic                       cmd_push;
    logic                       cmd_pop;
    ffd_pkg::cmd_t              cmd_in;
    ffd_pkg::cmd_t              cmd_out;
    logic                       frame_done;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ffd_pkg::BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ffd_pkg::BYTE_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= ffd_pkg::EXPECTED_LEN_RST;
        end
        else if (cfg_we)
        begin
            expected_len_reg <= cfg_data;
        end
    end

    ffd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rx_byte      (rx_byte),
        .full         (full),
        .expected_len (expected_len_reg),
        .q_full       (q_full),
        .frame_done   (frame_done),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    ffd_ram #(
        .WIDTH (ffd_pkg::BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffd_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wr_cmd (cmd_in),
        .full   (q_full),
        .pop    (cmd_pop),
        .rd_cmd (cmd_out),
        .empty  (q_empty)
    );

    ffd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (~q_empty),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .frame_done   (frame_done),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .last         (last),
        .status       (status)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for fixed_frame_deframer_xor_check: frames go in byte by byte, and
// a scoreboard class predicts the payload or status transactions that must come out.
// Depends on ffd_pkg and the deframer RTL only.
module tb;

    localparam int          BYTE_W       = ffd_pkg::BYTE_W;
    localparam int          LEN_W        = ffd_pkg::LEN_W;
    localparam int          LIMIT_CYCLES = 300000;
    localparam int          RANDOM_BYTES = 300;
    localparam logic [2:0]  FAULT_NONE   = 3'b000;
    localparam logic [2:0]  FAULT_SYNC   = 3'b001;
    localparam logic [2:0]  FAULT_LEN    = 3'b010;
    localparam logic [2:0]  FAULT_CSUM   = 3'b100;
    localparam logic [2:0]  FAULT_ALL    = 3'b111;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        ffd_pkg::status_t  st;
    } frame_result_t;

    class deframe_scoreboard;
        logic [BYTE_W-1:0] slot [ffd_pkg::MAX_PAYLOAD_DEF];
        logic [LEN_W-1:0]  len_reg;
        int unsigned       byte_count;
        logic [BYTE_W-1:0] run_xor;
        bit                sync_ok;
        bit                len_ok;
        frame_result_t     pending_results[$];
        int                mismatches;

        function new();
            foreach (slot[k])
                slot[k] = '0;
            len_reg    = ffd_pkg::EXPECTED_LEN_RST;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            byte_count = 0;
            run_xor    = '0;
            sync_ok    = 1'b1;
            len_ok     = 1'b1;
        endfunction

        function int unsigned frame_len();
            if (len_reg == 0)
                return 1;
            if (len_reg > ffd_pkg::MAX_PAYLOAD_DEF)
                return ffd_pkg::MAX_PAYLOAD_DEF;
            return len_reg;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            int unsigned      l;
            int unsigned      pos;
            ffd_pkg::status_t st;
            frame_result_t    r;
            l   = frame_len();
            pos = byte_count;
            if (pos == ffd_pkg::POS_SYNC0 && b != ffd_pkg::SYNC0)
                sync_ok = 1'b0;
            if (pos == ffd_pkg::POS_SYNC1 && b != ffd_pkg::SYNC1)
                sync_ok = 1'b0;
            if (pos == ffd_pkg::POS_SYNC2 && b != ffd_pkg::SYNC2)
                sync_ok = 1'b0;
            if (pos == ffd_pkg::POS_LEN && b != l)
                len_ok = 1'b0;
            if (pos >= ffd_pkg::HDR_BYTES && pos < ffd_pkg::HDR_BYTES + l)
                slot[pos - ffd_pkg::HDR_BYTES] = b;
            run_xor ^= b;
            if (pos + 1 < l + ffd_pkg::FRAME_EXTRA)
            begin
                byte_count = pos + 1;
                return;
            end
            st = ffd_pkg::ST_OK;
            if (!sync_ok)
                st = ffd_pkg::ST_SYNC;
            else if (!len_ok)
                st = ffd_pkg::ST_LEN;
            else if (run_xor != 0)
                st = ffd_pkg::ST_CSUM;
            restart();
            if (st != ffd_pkg::ST_OK)
            begin
                r = '{data: '0, last: 1'b1, st: st};
                pending_results = {pending_results, r};
                return;
            end
            for (int unsigned k = 0; k < l; k++)
            begin
                r = '{data: slot[k], last: (k + 1 == l), st: ffd_pkg::ST_OK};
                pending_results = {pending_results, r};
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [BYTE_W-1:0] data, logic lst, logic [1:0] st);
            frame_result_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected transaction data %h last %b status %0d",
                                 data, lst, st));
                return;
            end
            e = pending_results.pop_front();
            if (data !== e.data)
                report($sformatf("payload_byte %h, want %h", data, e.data));
            if (lst !== e.last)
                report($sformatf("last %b, want %b", lst, e.last));
            if (st !== e.st)
                report($sformatf("status %0d, want %0d", st, e.st));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] rx_byte;
    logic              empty;
    logic              pop;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic [1:0]        status;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_data;

    deframe_scoreboard sb;
    bit                idle_on;
    int                bytes_sent;
    int                cycle_count;

    fixed_frame_deframer_xor_check i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .payload_byte (payload_byte),
        .last         (last),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task set_len(input logic [LEN_W-1:0] v);
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        sb.len_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task send_frame(input int unsigned l, input logic [2:0] faults, input bit extremes);
        logic [BYTE_W-1:0] frame_q[$];
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] pb;
        int unsigned       idx;
        frame_q = {ffd_pkg::SYNC0, ffd_pkg::SYNC1, ffd_pkg::SYNC2, BYTE_W'(l)};
        if (faults & FAULT_SYNC)
        begin
            idx = $urandom_range(0, 2);
            frame_q[idx] ^= BYTE_W'($urandom_range(1, 255));
        end
        if (faults & FAULT_LEN)
            frame_q[ffd_pkg::POS_LEN] ^= BYTE_W'($urandom_range(1, 255));
        for (int unsigned k = 0; k < l; k++)
        begin
            pb      = extremes ? (k[0] ? 8'hFF : 8'h00) : BYTE_W'($urandom);
            frame_q = {frame_q, pb};
        end
        acc = '0;
        foreach (frame_q[k])
            acc ^= frame_q[k];
        if (faults & FAULT_CSUM)
            acc ^= BYTE_W'($urandom_range(1, 255));
        frame_q = {frame_q, acc};
        foreach (frame_q[k])
            send_byte(frame_q[k]);
    endtask

    task directed_frames();
        logic [BYTE_W-1:0] p0;
        logic [BYTE_W-1:0] p1;
        send_frame(sb.frame_len(), FAULT_NONE, 1'b1);
        set_len(6'd32);
        send_frame(sb.frame_len(), FAULT_NONE, 1'b1);
        set_len(6'd0);
        send_frame(sb.frame_len(), FAULT_NONE, 1'b0);
        // shrink mid-frame: header says 32, frame closes after one payload byte
        set_len(6'd63);
        p0 = BYTE_W'($urandom);
        send_byte(ffd_pkg::SYNC0);
        send_byte(ffd_pkg::SYNC1);
        send_byte(ffd_pkg::SYNC2);
        send_byte(8'd32);
        send_byte(p0);
        set_len(6'd1);
        send_byte(ffd_pkg::SYNC0 ^ ffd_pkg::SYNC1 ^ ffd_pkg::SYNC2 ^ 8'd32 ^ p0);
        // grow mid-frame: header says 1, frame carries two payload bytes
        p0 = BYTE_W'($urandom);
        p1 = BYTE_W'($urandom);
        send_byte(ffd_pkg::SYNC0);
        send_byte(ffd_pkg::SYNC1);
        send_byte(ffd_pkg::SYNC2);
        send_byte(8'd1);
        set_len(6'd2);
        send_byte(p0);
        send_byte(p1);
        send_byte(ffd_pkg::SYNC0 ^ ffd_pkg::SYNC1 ^ ffd_pkg::SYNC2 ^ 8'd1 ^ p0 ^ p1);
        send_frame(sb.frame_len(), FAULT_ALL, 1'b0);
        send_frame(sb.frame_len(), FAULT_LEN | FAULT_CSUM, 1'b0);
        send_frame(sb.frame_len(), FAULT_CSUM, 1'b0);
    endtask

    task random_frames(input int stop_at);
        int                pick;
        logic [LEN_W-1:0]  v;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = 6'd32;
            else if (pick == 1)
                v = ($urandom_range(0, 3) == 0) ? 6'd0 : LEN_W'($urandom_range(33, 63));
            else
                v = LEN_W'($urandom_range(1, 8));
            set_len(v);
            repeat ($urandom_range(2, 6))
            begin
                if (bytes_sent < stop_at)
                begin
                    if (bytes_sent > stop_at - 80)
                        idle_on = 1'b0;
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                    begin
                        repeat ($urandom_range(1, 10))
                            send_byte(BYTE_W'($urandom));
                        while (sb.byte_count != 0)
                            send_byte(BYTE_W'($urandom));
                    end
                    else if (pick < 4)
                        send_frame(sb.frame_len(), 3'($urandom_range(1, 7)), 1'b0);
                    else
                        send_frame(sb.frame_len(), FAULT_NONE, 1'b0);
                end
            end
        end
    endtask

    initial
    begin
        int pop_hold;
        pop      = 1'b0;
        pop_hold = 0;
        forever
        begin
            @(negedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                pop      <= 1'b0;
                pop_hold = $urandom_range(0, 2);
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(payload_byte, last, status);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb         = new();
        idle_on    = 1'b1;
        bytes_sent = 0;
        rst_n      = 1'b0;
        push       = 1'b0;
        rx_byte    = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_frames();
        random_frames(bytes_sent + RANDOM_BYTES);
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
